// ===== rtl/core/bmhq_pkg.sv =====
// shared types, constants and key conversion functions for the min-heap queue
`default_nettype none

package bmhq_pkg;

    localparam int CAPACITY  = 1023;
    localparam int KEY_WIDTH = 32;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int ADDR_W    = CNT_W;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 10;
    localparam int OUT_DATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;

    typedef logic signed [KEY_WIDTH-1:0] key_t;
    typedef logic signed [VALUE_W-1:0]   value_t;
    typedef logic [CNT_W-1:0]            cnt_t;
    typedef logic [ADDR_W-1:0]           addr_t;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic  we;
        addr_t waddr;
        key_t  wdata;
        addr_t raddr_a;
        addr_t raddr_b;
    } mem_req_t;

    typedef struct packed {
        logic    valid;
        value_t  popped;
        status_t status;
        cnt_t    count;
    } res_t;

    function automatic key_t to_key(input value_t v);
        return key_t'(v);
    endfunction

    function automatic value_t from_key(input key_t k);
        return value_t'(k);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bmhq_mem.sv =====
// heap key store with one write port and two registered read ports
`default_nettype none

module bmhq_mem
    import bmhq_pkg::*;
(
    input  wire logic     aclk,
    input  wire mem_req_t req,
    output key_t          rdata_a,
    output key_t          rdata_b
);

    key_t mem [0:CAPACITY];
    key_t rdata_a_reg;
    key_t rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_a_reg <= mem[req.raddr_a];
        rdata_b_reg <= mem[req.raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bmhq_cmp.sv =====
// shared signed key comparator
`default_nettype none

module bmhq_cmp
    import bmhq_pkg::*;
(
    input  wire key_t a,
    input  wire key_t b,
    output logic      lt
);

    assign lt = (a < b);

endmodule

`default_nettype wire

// ===== rtl/core/bmhq_seq.sv =====
// sift-up and sift-down sequencer driving the key store and the comparator
`default_nettype none

module bmhq_seq
    import bmhq_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire cmd_t   in_cmd,
    input  wire value_t in_value,
    input  wire logic   out_free,
    output res_t        res,
    output mem_req_t    mem_req,
    input  wire key_t   rdata_a,
    input  wire key_t   rdata_b
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_UP_RD   = 9'b000000010,
        S_UP_CMP  = 9'b000000100,
        S_POP_LD  = 9'b000001000,
        S_DN_RD   = 9'b000010000,
        S_DN_PICK = 9'b000100000,
        S_DN_CMP  = 9'b001000000,
        S_PUT     = 9'b010000000,
        S_DONE    = 9'b100000000
    } state_t;

    state_t  state_reg, state_next;
    cnt_t    cnt_reg, cnt_next;
    cnt_t    pos_reg, pos_next;
    key_t    key_reg, key_next;
    key_t    child_key_reg, child_key_next;
    cnt_t    child_pos_reg, child_pos_next;
    value_t  popped_reg, popped_next;
    status_t status_reg, status_next;

    key_t             cmp_a;
    key_t             cmp_b;
    logic             cmp_lt;
    logic [CNT_W:0]   lc;
    logic [CNT_W:0]   rc;
    logic             lc_ok;
    logic             rc_ok;
    logic             pick_b;

    bmhq_cmp u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .lt (cmp_lt)
    );

    assign lc     = {pos_reg, 1'b0};
    assign rc     = {pos_reg, 1'b1};
    assign lc_ok  = (lc <= {1'b0, cnt_reg});
    assign rc_ok  = (rc <= {1'b0, cnt_reg});
    assign pick_b = rc_ok && cmp_lt;

    always_comb begin
        cmp_a = key_reg;
        cmp_b = rdata_a;
        case (state_reg)
            S_DN_PICK: begin
                cmp_a = rdata_b;
                cmp_b = rdata_a;
            end
            S_DN_CMP: begin
                cmp_a = child_key_reg;
                cmp_b = key_reg;
            end
            default: begin
                cmp_a = key_reg;
                cmp_b = rdata_a;
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        key_next       = key_reg;
        child_key_next = child_key_reg;
        child_pos_next = child_pos_reg;
        popped_next    = popped_reg;
        status_next    = status_reg;
        mem_req        = '0;
        mem_req.raddr_a = addr_t'(1);
        mem_req.raddr_b = addr_t'(cnt_reg);
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    popped_next = '0;
                    status_next = ST_OK;
                    if (in_cmd == CMD_PUSH) begin
                        if (cnt_reg == cnt_t'(CAPACITY)) begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end else begin
                            cnt_next = cnt_reg + cnt_t'(1);
                            pos_next = cnt_reg + cnt_t'(1);
                            key_next = to_key(in_value);
                            if (cnt_reg == '0) begin
                                state_next = S_PUT;
                            end else begin
                                state_next = S_UP_RD;
                            end
                        end
                    end else begin
                        if (cnt_reg == '0) begin
                            status_next = ST_EMPTY;
                            state_next  = S_DONE;
                        end else begin
                            state_next = S_POP_LD;
                        end
                    end
                end
            end
            S_UP_RD: begin
                mem_req.raddr_a = addr_t'(pos_reg >> 1);
                state_next      = S_UP_CMP;
            end
            S_UP_CMP: begin
                if (cmp_lt) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = addr_t'(pos_reg);
                    mem_req.wdata = rdata_a;
                    pos_next      = pos_reg >> 1;
                    if ((pos_reg >> 1) == cnt_t'(1)) begin
                        state_next = S_PUT;
                    end else begin
                        state_next = S_UP_RD;
                    end
                end else begin
                    state_next = S_PUT;
                end
            end
            S_POP_LD: begin
                popped_next = from_key(rdata_a);
                key_next    = rdata_b;
                cnt_next    = cnt_reg - cnt_t'(1);
                pos_next    = cnt_t'(1);
                state_next  = S_DN_RD;
            end
            S_DN_RD: begin
                mem_req.raddr_a = lc[ADDR_W-1:0];
                mem_req.raddr_b = rc[ADDR_W-1:0];
                if (lc_ok) begin
                    state_next = S_DN_PICK;
                end else begin
                    state_next = S_PUT;
                end
            end
            S_DN_PICK: begin
                child_key_next = pick_b ? rdata_b : rdata_a;
                child_pos_next = pick_b ? rc[CNT_W-1:0] : lc[CNT_W-1:0];
                state_next     = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (cmp_lt) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = addr_t'(pos_reg);
                    mem_req.wdata = child_key_reg;
                    pos_next      = child_pos_reg;
                    state_next    = S_DN_RD;
                end else begin
                    state_next = S_PUT;
                end
            end
            S_PUT: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = addr_t'(pos_reg);
                mem_req.wdata = key_reg;
                state_next    = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        pos_reg       <= pos_next;
        key_reg       <= key_next;
        child_key_reg <= child_key_next;
        child_pos_reg <= child_pos_next;
        popped_reg    <= popped_next;
        status_reg    <= status_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign res.valid  = (state_reg == S_DONE);
    assign res.popped = popped_reg;
    assign res.status = status_reg;
    assign res.count  = cnt_reg;

endmodule

`default_nettype wire

// ===== rtl/core/binary_min_heap_queue_unit.sv =====
// top level of the binary min-heap priority queue with output register
//
// usage: each input beat on the s_ channel is a push (s_tuser = 0, key in
// s_tdata) or a pop (s_tuser = 1, s_tdata ignored). every input beat gives
// exactly one output beat on the m_ channel carrying the popped key (zero
// unless a pop succeeded), the status in m_tuser (ok, full, empty) and the
// entry count after the operation.
// operation: the sequencer walks one heap level per step using the shared
// comparator and the two-read, one-write key store. refused pushes and empty
// pops skip the key store and go straight to the result.
// one item is in flight at a time; s_tready is high only while idle.
// the result sits in an output register, so the next beat is accepted while
// a result waits; if the receiver stalls, the following result holds the
// sequencer until the register frees up.
// reset empties the queue; the key store needs no clearing pass.
`default_nettype none

module binary_min_heap_queue_unit
    import bmhq_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [VALUE_W-1:0]    s_tdata,   // value
    input  wire logic                  s_tuser,   // cmd
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // popped_value, count, zero pad
    output logic [1:0]                 m_tuser    // status
);

    mem_req_t mem_req;
    key_t     rdata_a;
    key_t     rdata_b;
    res_t     res;
    logic     out_free;

    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [1:0]            m_tuser_reg;

    bmhq_mem u_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    bmhq_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_cmd   (cmd_t'(s_tuser)),
        .in_value (value_t'(s_tdata)),
        .out_free (out_free),
        .res      (res),
        .mem_req  (mem_req),
        .rdata_a  (rdata_a),
        .rdata_b  (rdata_b)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= res.valid;
        end
        if (out_free && res.valid) begin
            m_tdata_reg <= OUT_DATA_W'({COUNT_W'(res.count), res.popped});
            m_tuser_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while sequencer busy");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_FULL) |-> (m_tdata[VALUE_W +: COUNT_W] == COUNT_W'(CAPACITY)))
        else $error("full status with count below capacity");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_EMPTY) |->
            (m_tdata[VALUE_W +: COUNT_W] == '0) && (m_tdata[VALUE_W-1:0] == '0))
        else $error("empty status with nonzero count or key");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_OK) || (m_tuser == ST_FULL) || (m_tuser == ST_EMPTY))
        else $error("undefined status code");

endmodule

`default_nettype wire
